// File: hw/rtl/assert_macros.svh
// assertion helpers used by inverse_tone_curve_bisection.sv
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every rising edge outside of reset
`define ITCB_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// checked on every rising edge, reset included
`define ITCB_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) \
    else $error(msg);

`endif

// File: hw/rtl/itcb_pkg.sv
package itcb_pkg;

  // width of the luminance fields and of the register data
  localparam int LUMA_W = 16;

  // register index
  localparam int CFG_IDX_W = 4;
  localparam logic [CFG_IDX_W-1:0] CFG_BACKLIGHT_SCALE   = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_SHADOW_DETAIL     = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_PERCEIVED_GAIN    = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] CFG_HIGHLIGHT_PROTECT = CFG_IDX_W'(3);

  // register values after reset
  localparam logic [LUMA_W-1:0] RST_BACKLIGHT_SCALE   = 16'd32768;
  localparam logic [LUMA_W-1:0] RST_SHADOW_DETAIL     = 16'd16384;
  localparam logic [LUMA_W-1:0] RST_PERCEIVED_GAIN    = 16'd32768;
  localparam logic [LUMA_W-1:0] RST_HIGHLIGHT_PROTECT = 16'd22938;

endpackage

// File: hw/rtl/itcb_div.sv
module itcb_div #(
  parameter int NW = 30,
  parameter int DW = 17,
  parameter int QW = 17
) (
  input  logic          clk,
  input  logic          en,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic [QW-1:0] quo
);
  import itcb_pkg::*;

  localparam int XW = (NW > DW + QW) ? NW : DW + QW;

  logic [XW-1:0] rem_r [QW];
  logic [DW-1:0] den_r [QW];
  logic [QW-1:0] quo_r [QW];

  // restoring division, one quotient bit per stage, msb first
  always_ff @(posedge clk) begin : p_div
    logic [XW-1:0] rin;
    logic [XW-1:0] shd;
    logic [DW-1:0] dn;
    logic [QW-1:0] qn;
    if (en) begin
      for (int i = 0; i < QW; i++) begin
        if (i == 0) begin
          rin = XW'(num);
          dn  = den;
          qn  = '0;
        end else begin
          rin = rem_r[i-1];
          dn  = den_r[i-1];
          qn  = quo_r[i-1];
        end
        shd = XW'(dn) << (QW - 1 - i);
        if (rin >= shd) begin
          rem_r[i] <= rin - shd;
          quo_r[i] <= qn | (QW'(1) << (QW - 1 - i));
        end else begin
          rem_r[i] <= rin;
          quo_r[i] <= qn;
        end
        den_r[i] <= dn;
      end
    end
  end

  assign quo = quo_r[QW-1];

endmodule

// File: hw/rtl/itcb_step.sv
module itcb_step #(
  parameter int FRACTION_BITS = 15
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        en,
  input  logic                        in_valid,
  input  logic [FRACTION_BITS:0]      in_lo,
  input  logic [FRACTION_BITS:0]      in_hi,
  input  logic [itcb_pkg::LUMA_W-1:0] in_d,
  input  logic [FRACTION_BITS:0]      scale,
  input  logic [FRACTION_BITS:0]      one_minus_scale,
  input  logic [FRACTION_BITS:0]      black,
  input  logic                        hi_pass,
  input  logic [itcb_pkg::LUMA_W-1:0] gain,
  input  logic [FRACTION_BITS:0]      highlight,
  output logic                        out_valid,
  output logic [FRACTION_BITS:0]      out_lo,
  output logic [FRACTION_BITS:0]      out_hi,
  output logic [itcb_pkg::LUMA_W-1:0] out_d
);
  import itcb_pkg::*;

  localparam int F    = FRACTION_BITS;
  localparam int VW   = F + 1;
  localparam int YW   = F;
  localparam int QW   = F + 2;
  localparam int NW   = 2 * F;
  localparam int DENW = F + 2;
  localparam int TW   = F + 2;
  localparam int PW   = YW + VW;
  localparam int SW   = ((F + 2 > LUMA_W) ? F + 2 : LUMA_W) + 1;
  localparam int CW   = (VW > LUMA_W) ? VW : LUMA_W;
  localparam int MW   = SW - 1 + VW;
  localparam int GW   = VW + LUMA_W;
  localparam int L    = QW;

  localparam logic [VW-1:0] ONE   = VW'(1) << F;
  localparam logic [TW-1:0] THREE = TW'(3) << F;

  typedef struct packed {
    logic [VW-1:0]     lo;
    logic [VW-1:0]     hi;
    logic [LUMA_W-1:0] d;
    logic [YW-1:0]     y;
    logic              pass;
    logic              sat;
  } pay_t;

  // stage registers
  logic              m_v_r, a_v_r, d_v_r, e_v_r, g_v_r, h_v_r, i_v_r, j_v_r, o_v_r;
  logic [L-1:0]      pv_r;
  pay_t              m_r, a_r, d_r, e_r, g_r, h_r, i_r, j_r;
  pay_t              pl_r [L];
  logic [PW-1:0]     a_p_r;
  logic [YW-1:0]     a_t1n_r;
  logic [VW-1:0]     d_map_r, d_t1_r, e_map_r, e_t1_r, e_tt1_r, g_map_r, g_ss1_r, g_ss2_r;
  logic [YW-1:0]     d_t2_r, e_t2_r, e_tt2_r;
  logic [QW-1:0]     d_ys_r, e_ys_r, g_ys_r, h_ys_r, i_ys_r;
  logic [VW-1:0]     h_l1_r, h_w_r, i_w_r;
  logic [LUMA_W-1:0] i_v1_r, j_v1_r;
  logic [MW-1:0]     j_m_r;
  logic              j_neg_r;
  logic [VW-1:0]     o_lo_r, o_hi_r;
  logic [LUMA_W-1:0] o_d_r;

  // combinational terms
  logic [VW:0]       mid_sum;
  logic [VW-1:0]     a_y_ext;
  pay_t              a_nxt;
  pay_t              b_pay;
  logic              b_sat;
  logic [DENW-1:0]   den_map;
  logic [NW-1:0]     num_y, num_t1;
  logic [QW-1:0]     q_map, q_t1, q_ys;
  pay_t              dv;
  logic [VW-1:0]     map_c, t1_c;
  logic [YW-1:0]     t2_c;
  logic [2*VW-1:0]   sq1;
  logic [2*YW-1:0]   sq2;
  logic [TW-1:0]     k1, k2;
  logic [VW+TW-1:0]  sp1, sp2;
  logic [VW-1:0]     dmap;
  logic [2*VW-1:0]   lp, wp;
  logic [GW-1:0]     gp;
  logic [SW-1:0]     diff;
  logic [SW-2:0]     mag;
  logic [SW-2:0]     delta;
  logic [SW:0]       v2;
  logic [VW-1:0]     v2c, fwd;
  logic              go_lo;

  // valid bits travel with the data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_v_r <= 1'b0;
      a_v_r <= 1'b0;
      pv_r  <= '0;
      d_v_r <= 1'b0;
      e_v_r <= 1'b0;
      g_v_r <= 1'b0;
      h_v_r <= 1'b0;
      i_v_r <= 1'b0;
      j_v_r <= 1'b0;
      o_v_r <= 1'b0;
    end else if (en) begin
      m_v_r <= in_valid;
      a_v_r <= m_v_r;
      pv_r  <= {pv_r[L-2:0], a_v_r};
      d_v_r <= pv_r[L-1];
      e_v_r <= d_v_r;
      g_v_r <= e_v_r;
      h_v_r <= g_v_r;
      i_v_r <= h_v_r;
      j_v_r <= i_v_r;
      o_v_r <= j_v_r;
    end
  end

  // probe point of this step and its pass-through flag
  always_comb begin
    mid_sum    = (VW+1)'(in_lo) + (VW+1)'(in_hi);
    a_y_ext    = VW'(m_r.y);
    a_nxt      = m_r;
    a_nxt.pass = (a_y_ext <= black) || hi_pass;
  end

  // pass-through test, shoulder denominator product, smoothstep input
  always_ff @(posedge clk) begin
    if (en) begin
      m_r.lo   <= in_lo;
      m_r.hi   <= in_hi;
      m_r.d    <= in_d;
      m_r.y    <= mid_sum[YW:1];
      m_r.pass <= 1'b0;
      m_r.sat  <= 1'b0;

      a_r      <= a_nxt;
      a_p_r    <= PW'(m_r.y) * PW'(one_minus_scale);
      a_t1n_r  <= (a_y_ext > black) ? YW'(a_y_ext - black) : '0;
    end
  end

  // divider operands
  always_comb begin
    b_sat   = (VW'(a_t1n_r) >= black) || (black == '0);
    den_map = DENW'(a_p_r >> F) + DENW'(scale);
    num_y   = {a_r.y, {F{1'b0}}};
    num_t1  = b_sat ? '0 : {a_t1n_r, {F{1'b0}}};
    b_pay     = a_r;
    b_pay.sat = b_sat;
  end

  itcb_div #(.NW(NW), .DW(DENW), .QW(QW)) u_div_map (
    .clk (clk), .en (en), .num (num_y), .den (den_map), .quo (q_map)
  );

  itcb_div #(.NW(NW), .DW(VW), .QW(QW)) u_div_t1 (
    .clk (clk), .en (en), .num (num_t1), .den (black), .quo (q_t1)
  );

  itcb_div #(.NW(NW), .DW(VW), .QW(QW)) u_div_ys (
    .clk (clk), .en (en), .num (num_y), .den (scale), .quo (q_ys)
  );

  // payload delay line alongside the dividers
  always_ff @(posedge clk) begin
    if (en) begin
      pl_r[0] <= b_pay;
      for (int i = 1; i < L; i++) begin
        pl_r[i] <= pl_r[i-1];
      end
    end
  end

  // quotient saturation and ramps
  always_comb begin
    dv    = pl_r[L-1];
    map_c = (q_map > QW'(ONE)) ? ONE : VW'(q_map);
    t1_c  = dv.sat ? ONE : VW'(q_t1);
    t2_c  = dv.y[YW-1] ? {dv.y[YW-2:0], 1'b0} : '0;
  end

  // smoothstep terms and blends
  always_comb begin
    sq1  = (2*VW)'(d_t1_r) * (2*VW)'(d_t1_r);
    sq2  = (2*YW)'(d_t2_r) * (2*YW)'(d_t2_r);
    k1   = THREE - (TW'(e_t1_r) << 1);
    k2   = THREE - (TW'(e_t2_r) << 1);
    sp1  = (VW+TW)'(e_tt1_r) * (VW+TW)'(k1);
    sp2  = (VW+TW)'(e_tt2_r) * (VW+TW)'(k2);
    dmap = g_map_r - VW'(g_r.y);
    lp   = (2*VW)'(dmap) * (2*VW)'(g_ss1_r);
    wp   = (2*VW)'(highlight) * (2*VW)'(g_ss2_r);
    gp   = GW'(h_l1_r) * GW'(gain);
    diff = SW'(i_ys_r) - SW'(i_v1_r);
    mag  = diff[SW-1] ? (SW-1)'(-diff) : (SW-1)'(diff);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_r     <= dv;
      d_map_r <= map_c;
      d_t1_r  <= t1_c;
      d_t2_r  <= t2_c;
      d_ys_r  <= q_ys;

      e_r     <= d_r;
      e_map_r <= d_map_r;
      e_t1_r  <= d_t1_r;
      e_t2_r  <= d_t2_r;
      e_ys_r  <= d_ys_r;
      e_tt1_r <= VW'(sq1 >> F);
      e_tt2_r <= YW'(sq2 >> F);

      g_r     <= e_r;
      g_map_r <= e_map_r;
      g_ys_r  <= e_ys_r;
      g_ss1_r <= VW'(sp1 >> F);
      g_ss2_r <= VW'(sp2 >> F);

      h_r     <= g_r;
      h_ys_r  <= g_ys_r;
      h_l1_r  <= VW'(g_r.y) + VW'(lp >> F);
      h_w_r   <= VW'(wp >> F);

      i_r     <= h_r;
      i_ys_r  <= h_ys_r;
      i_w_r   <= h_w_r;
      i_v1_r  <= gp[F+LUMA_W-1:F];

      j_r     <= i_r;
      j_v1_r  <= i_v1_r;
      j_m_r   <= MW'(mag) * MW'(i_w_r);
      j_neg_r <= diff[SW-1];
    end
  end

  // highlight blend, clamp and bisection decision
  always_comb begin
    delta = (SW-1)'(j_m_r >> F);
    v2    = j_neg_r ? ((SW+1)'(j_v1_r) - (SW+1)'(delta))
                    : ((SW+1)'(j_v1_r) + (SW+1)'(delta));
    if (v2[SW]) begin
      v2c = '0;
    end else if (v2 > (SW+1)'(ONE)) begin
      v2c = ONE;
    end else begin
      v2c = VW'(v2);
    end
    fwd   = j_r.pass ? VW'(j_r.y) : v2c;
    go_lo = CW'(fwd) < CW'(j_r.d);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      o_lo_r <= go_lo ? VW'(j_r.y) : j_r.lo;
      o_hi_r <= go_lo ? j_r.hi : VW'(j_r.y);
      o_d_r  <= j_r.d;
    end
  end

  assign out_valid = o_v_r;
  assign out_lo    = o_lo_r;
  assign out_hi    = o_hi_r;
  assign out_d     = o_d_r;

endmodule

// File: hw/rtl/inverse_tone_curve_bisection.sv
// Inverse backlight-compensation tone curve.
// Input channel in_*: one displayed luminance (Q15) per transaction. Result channel
// out_*: the scene luminance whose forward curve value brackets it, found by
// BISECT_STEPS halvings of [0, 1]. Register channel cfg_*: index and 16-bit data,
// always ready; a write blocks new input while the black level and the clamped
// scale are recomputed.
// Throughput: one transaction per clock unless the receiver stalls or a register
// write holds input off. Every bisection step is its own pipeline section, built
// around three pipelined restoring dividers of FRACTION_BITS + 2 stages each.
// Reset clears all valid bits and loads the default registers; in_tready stays low
// after reset and after any register write until the derived values settle.
// When the receiver stalls (out_tvalid high, out_tready low) the whole pipeline
// holds and in_tready drops; nothing is lost or repeated.
`include "assert_macros.svh"

module inverse_tone_curve_bisection #(
  parameter int BISECT_STEPS  = 14,
  parameter int FRACTION_BITS = 15
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [itcb_pkg::LUMA_W-1:0]    in_tdata,   // [15:0] displayed_luma
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [itcb_pkg::LUMA_W-1:0]    out_tdata,  // [15:0] scene_luma
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [itcb_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [itcb_pkg::LUMA_W-1:0]    cfg_data
);
  import itcb_pkg::*;

  localparam int F        = FRACTION_BITS;
  localparam int VW       = F + 1;
  localparam int CW       = (VW > LUMA_W) ? VW : LUMA_W;
  localparam int HPW      = VW + 14;
  localparam int BNW      = F + 9;
  localparam int QB       = F - 4;
  localparam int RK       = BNW + 14;
  localparam int RMW      = RK - 13;
  localparam int BPW      = BNW + RMW;
  localparam int BUSY_CYC = 2;
  localparam int BCW      = $clog2(BUSY_CYC + 1);

  localparam logic [VW-1:0]  ONE      = VW'(1) << F;
  localparam logic [VW-1:0]  QUARTER  = VW'(1) << (F - 2);
  localparam logic [HPW-1:0] HP_LIM   = HPW'(9999) << F;
  localparam logic [BNW-1:0] BLK_BASE = (BNW'(300) << F) + BNW'(5000);
  // reciprocal of 10000, exact for every numerator below 2^BNW
  localparam logic [RMW-1:0] BLK_RECIP = RMW'(((64'd1 << RK) + 64'd9999) / 64'd10000);

  // register file
  logic [LUMA_W-1:0] scale_cfg_r, shadow_cfg_r, gain_cfg_r, hl_cfg_r;
  // derived values
  logic [VW-1:0]     scale_r, omsc_r, hl_r;
  logic              hi_pass_r;
  logic [CW-1:0]     s_ext, sh_ext, hl_ext;
  logic [VW-1:0]     s_cl, sh_cl, hl_cl;
  logic [BNW-1:0]    blk_num;
  logic [BPW-1:0]    blk_prod;
  logic [QB-1:0]     blk_q;
  logic [VW-1:0]     black_r;
  logic [BCW-1:0]    busy_cnt_r;
  logic              cfg_wr;
  // pipeline control
  logic              en;
  logic              out_valid_r;
  logic [LUMA_W-1:0] out_data_r;
  logic [VW:0]       res_sum;

  wire [BISECT_STEPS:0] st_v;
  wire [VW-1:0]         st_lo [BISECT_STEPS+1];
  wire [VW-1:0]         st_hi [BISECT_STEPS+1];
  wire [LUMA_W-1:0]     st_d  [BISECT_STEPS+1];

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;

  // register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_cfg_r  <= RST_BACKLIGHT_SCALE;
      shadow_cfg_r <= RST_SHADOW_DETAIL;
      gain_cfg_r   <= RST_PERCEIVED_GAIN;
      hl_cfg_r     <= RST_HIGHLIGHT_PROTECT;
    end else if (cfg_wr) begin
      unique case (cfg_index)
        CFG_BACKLIGHT_SCALE:   scale_cfg_r  <= cfg_data;
        CFG_SHADOW_DETAIL:     shadow_cfg_r <= cfg_data;
        CFG_PERCEIVED_GAIN:    gain_cfg_r   <= cfg_data;
        CFG_HIGHLIGHT_PROTECT: hl_cfg_r     <= cfg_data;
        default: ;
      endcase
    end
  end

  // clamps and black level = numerator / 10000 by reciprocal multiplication
  always_comb begin
    s_ext  = CW'(scale_cfg_r);
    sh_ext = CW'(shadow_cfg_r);
    hl_ext = CW'(hl_cfg_r);
    if (s_ext < CW'(QUARTER)) begin
      s_cl = QUARTER;
    end else if (s_ext > CW'(ONE)) begin
      s_cl = ONE;
    end else begin
      s_cl = VW'(s_ext);
    end
    sh_cl    = (sh_ext > CW'(ONE)) ? ONE : VW'(sh_ext);
    hl_cl    = (hl_ext > CW'(ONE)) ? ONE : VW'(hl_ext);
    blk_num  = BLK_BASE - BNW'(sh_cl) * BNW'(280);
    blk_prod = BPW'(blk_num) * BPW'(BLK_RECIP);
    blk_q    = QB'(blk_prod >> RK);
  end

  always_ff @(posedge clk) begin
    scale_r   <= s_cl;
    omsc_r    <= ONE - s_cl;
    hl_r      <= hl_cl;
    hi_pass_r <= (HPW'(s_cl) * HPW'(10000)) >= HP_LIM;
    black_r   <= VW'(blk_q);
  end

  // input held off until derived values settle
  always_ff @(posedge clk) begin
    if (!rst_n || cfg_wr) begin
      busy_cnt_r <= BCW'(BUSY_CYC);
    end else if (busy_cnt_r != '0) begin
      busy_cnt_r <= busy_cnt_r - BCW'(1);
    end
  end

  assign en        = !out_valid_r || out_tready;
  assign in_tready = en && (busy_cnt_r == '0);

  assign st_v[0]  = in_tvalid && in_tready;
  assign st_lo[0] = '0;
  assign st_hi[0] = ONE;
  assign st_d[0]  = in_tdata;

  // bisection steps
  for (genvar k = 0; k < BISECT_STEPS; k++) begin : g_step
    itcb_step #(.FRACTION_BITS(FRACTION_BITS)) u_step (
      .clk             (clk),
      .rst_n           (rst_n),
      .en              (en),
      .in_valid        (st_v[k]),
      .in_lo           (st_lo[k]),
      .in_hi           (st_hi[k]),
      .in_d            (st_d[k]),
      .scale           (scale_r),
      .one_minus_scale (omsc_r),
      .black           (black_r),
      .hi_pass         (hi_pass_r),
      .gain            (gain_cfg_r),
      .highlight       (hl_r),
      .out_valid       (st_v[k+1]),
      .out_lo          (st_lo[k+1]),
      .out_hi          (st_hi[k+1]),
      .out_d           (st_d[k+1])
    );
  end

  // final midpoint into the output register
  assign res_sum = (VW+1)'(st_lo[BISECT_STEPS]) + (VW+1)'(st_hi[BISECT_STEPS]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= st_v[BISECT_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data_r <= LUMA_W'(res_sum >> 1);
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  `ITCB_ASSERT(a_cfg_holds_input, cfg_valid && cfg_ready |=> !in_tready, "input open after write")
  `ITCB_ASSERT(a_bracket_order, st_v[BISECT_STEPS] |-> st_lo[BISECT_STEPS] <= st_hi[BISECT_STEPS], "bisection bracket inverted")
  `ITCB_ASSERT(a_stall_freezes, out_tvalid && !out_tready |=> $stable(st_v[BISECT_STEPS:1]), "pipeline moved during stall")
  `ITCB_ASSERT(a_stall_blocks, out_tvalid && !out_tready |-> !in_tready, "input open during stall")
  `ITCB_ASSERT_ALWAYS(a_reset_clears, !rst_n |=> !out_tvalid && !in_tready, "reset left output valid")

endmodule
